### rtl/pcbf_pkg.sv
package pcbf_pkg;

    localparam int unsigned STORE_DEPTH_DEF = 4096;
    localparam int unsigned MAX_XFER_DEF    = 8;

    localparam int unsigned CAP_W  = 13;
    localparam int unsigned LEN_W  = 4;
    localparam int unsigned DATA_W = 64;
    localparam int unsigned TOT_W  = 8;
    localparam int unsigned BYTES  = DATA_W / 8;

    localparam int unsigned S_TDATA_W = 72;
    localparam int unsigned S_TUSER_W = 3;
    localparam int unsigned M_TDATA_W = 96;

    typedef enum logic [2:0] {
        REQ_SEND   = 3'd0,
        REQ_RECV   = 3'd1,
        REQ_POLL   = 3'd2,
        REQ_ADD_RD = 3'd3,
        REQ_ADD_WR = 3'd4,
        REQ_DEL_RD = 3'd5,
        REQ_DEL_WR = 3'd6
    } t_req;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_PIPE  = 3'd1,
        ST_BLOCK = 3'd2,
        ST_EOS   = 3'd3,
        ST_COUNT = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        B_IDLE,
        B_SEND,
        B_RECV
    } t_bstate;

    typedef struct packed {
        t_req              req;
        logic [LEN_W-1:0]  len;
        logic [DATA_W-1:0] wdata;
        logic              ask_r;
        logic              ask_w;
    } t_cmd;

    typedef struct packed {
        t_status           status;
        logic [LEN_W-1:0]  byte_count;
        logic [DATA_W-1:0] read_data;
        logic              poll_in;
        logic              poll_out;
        logic              poll_hup;
        logic              poll_err;
        logic [CAP_W-1:0]  free_bytes;
        logic              released;
    } t_rsp;

endpackage

### rtl/pcbf_front.sv
module pcbf_front
    import pcbf_pkg::*;
#(
    parameter int unsigned MAX_XFER = MAX_XFER_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    input  logic [S_TUSER_W-1:0] s_axis_tuser,
    output t_cmd                 o_cmd,
    output logic                 o_cmd_valid,
    input  logic                 i_cmd_pop
);

    localparam int unsigned QD  = 2;
    localparam int unsigned QAW = $clog2(QD);

    t_cmd             r_q [QD];
    logic [QAW-1:0]   r_wp, r_rp;
    logic [QAW:0]     r_cnt;
    t_cmd             dec;
    logic [LEN_W-1:0] len_raw;
    logic             push, pop;

    always_comb begin
        len_raw   = s_axis_tdata[LEN_W-1:0];
        dec.req   = t_req'(s_axis_tuser);
        dec.len   = (len_raw > LEN_W'(MAX_XFER)) ? LEN_W'(MAX_XFER) : len_raw;
        dec.wdata = s_axis_tdata[LEN_W +: DATA_W];
        dec.ask_r = s_axis_tdata[LEN_W + DATA_W];
        dec.ask_w = s_axis_tdata[LEN_W + DATA_W + 1];
    end

    assign s_axis_tready = (r_cnt != (QAW+1)'(QD));
    assign push          = s_axis_tvalid && s_axis_tready;
    assign pop           = i_cmd_pop && o_cmd_valid;
    assign o_cmd_valid   = (r_cnt != '0);
    assign o_cmd         = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= dec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

### rtl/pcbf_back.sv
module pcbf_back
    import pcbf_pkg::*;
#(
    parameter int unsigned STORE_DEPTH = STORE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [CAP_W-1:0] i_cfg_wr_data,
    input  t_cmd             i_cmd,
    input  logic             i_cmd_valid,
    output logic             o_cmd_pop,
    output t_rsp             o_rsp,
    output logic             o_rsp_valid,
    input  logic             i_rsp_ready
);

    localparam int unsigned AW = $clog2(STORE_DEPTH);
    localparam int unsigned CW = $clog2(STORE_DEPTH + 1);

    logic [7:0]        mem [STORE_DEPTH];
    logic [7:0]        r_mem_q;

    t_bstate           r_state, n_state;
    logic [CW-1:0]     r_cap, n_cap;
    logic [AW-1:0]     r_wpos, n_wpos, r_rpos, n_rpos;
    logic [CW-1:0]     r_fill, n_fill;
    logic [TOT_W-1:0]  r_rd_tot, n_rd_tot, r_wr_tot, n_wr_tot;
    logic [LEN_W-1:0]  r_xcnt, n_xcnt, r_idx, n_idx;
    logic [DATA_W-1:0] r_wdata, n_wdata, r_rdata, n_rdata;
    logic              r_rd_pend, n_rd_pend;
    logic [2:0]        r_rd_slot, n_rd_slot;
    logic              r_o_valid, n_o_valid;
    t_rsp              r_rsp, n_rsp;

    logic              out_free, start, mem_we;
    logic [7:0]        mem_wbyte;
    logic [CW-1:0]     space, cfg_cap;
    t_rsp              d_rsp;
    logic [LEN_W-1:0]  d_count;
    logic              d_send, d_recv, d_empty;
    logic [DATA_W-1:0] rdata_upd;

    function automatic logic [AW-1:0] bump(input logic [AW-1:0] p, input logic [CW-1:0] cap);
        logic [CW-1:0] nx;
        nx = CW'(p) + 1'b1;
        return (nx >= cap) ? '0 : AW'(nx);
    endfunction

    assign out_free    = !r_o_valid || i_rsp_ready;
    assign start       = (r_state == B_IDLE) && i_cmd_valid && out_free;
    assign o_cmd_pop   = start;
    assign o_rsp       = r_rsp;
    assign o_rsp_valid = r_o_valid;
    assign space       = r_cap - r_fill;

    always_comb begin
        if (i_cfg_wr_data == '0) begin
            cfg_cap = CW'(1);
        end else if (32'(i_cfg_wr_data) > 32'(STORE_DEPTH)) begin
            cfg_cap = CW'(STORE_DEPTH);
        end else begin
            cfg_cap = CW'(i_cfg_wr_data);
        end
    end

    // request decision at dispatch
    always_comb begin
        d_rsp    = '0;
        d_rsp.status = ST_OK;
        d_count  = '0;
        d_send   = 1'b0;
        d_recv   = 1'b0;
        d_empty  = 1'b0;
        n_rd_tot = r_rd_tot;
        n_wr_tot = r_wr_tot;
        case (i_cmd.req)
            REQ_SEND: begin
                if (i_cmd.len != '0) begin
                    if (r_rd_tot == '0) begin
                        d_rsp.status = ST_PIPE;
                    end else if (space == '0) begin
                        d_rsp.status = ST_BLOCK;
                    end else begin
                        d_count = (CW'(i_cmd.len) < space) ? i_cmd.len : LEN_W'(space);
                        d_send  = 1'b1;
                    end
                end
            end
            REQ_RECV: begin
                if (i_cmd.len != '0) begin
                    if (r_fill == '0) begin
                        d_rsp.status = (r_wr_tot == '0) ? ST_EOS : ST_BLOCK;
                    end else begin
                        d_count = (CW'(i_cmd.len) < r_fill) ? i_cmd.len : LEN_W'(r_fill);
                        d_recv  = 1'b1;
                    end
                end
            end
            REQ_POLL: begin
                d_rsp.poll_in  = i_cmd.ask_r && ((r_fill != '0) || (r_wr_tot == '0));
                d_rsp.poll_hup = i_cmd.ask_r && (r_wr_tot == '0);
                d_rsp.poll_out = i_cmd.ask_w && (r_fill < r_cap) && (r_rd_tot != '0);
                d_rsp.poll_err = i_cmd.ask_w && (r_rd_tot == '0);
            end
            REQ_ADD_RD: begin
                if (r_rd_tot != '1) begin
                    n_rd_tot = r_rd_tot + 1'b1;
                end
            end
            REQ_ADD_WR: begin
                if (r_wr_tot != '1) begin
                    n_wr_tot = r_wr_tot + 1'b1;
                end
            end
            REQ_DEL_RD: begin
                if (r_rd_tot == '0) begin
                    d_rsp.status = ST_COUNT;
                end else begin
                    n_rd_tot = r_rd_tot - 1'b1;
                    d_empty  = (r_rd_tot == TOT_W'(1)) && (r_wr_tot == '0);
                end
            end
            REQ_DEL_WR: begin
                if (r_wr_tot == '0) begin
                    d_rsp.status = ST_COUNT;
                end else begin
                    n_wr_tot = r_wr_tot - 1'b1;
                    d_empty  = (r_wr_tot == TOT_W'(1)) && (r_rd_tot == '0);
                end
            end
            default: begin
            end
        endcase
        d_rsp.released = d_empty;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE: begin
                if (start && d_send) begin
                    n_state = B_SEND;
                end else if (start && d_recv) begin
                    n_state = B_RECV;
                end
            end
            B_SEND: begin
                if (r_idx == r_xcnt - 1'b1) begin
                    n_state = B_IDLE;
                end
            end
            B_RECV: begin
                if (r_rd_pend && (r_rd_slot == 3'(r_xcnt - 1'b1))) begin
                    n_state = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_comb begin
        n_cap     = r_cap;
        n_wpos    = r_wpos;
        n_rpos    = r_rpos;
        n_fill    = r_fill;
        n_xcnt    = r_xcnt;
        n_idx     = r_idx;
        n_wdata   = r_wdata;
        n_rdata   = r_rdata;
        n_rd_pend = 1'b0;
        n_rd_slot = r_rd_slot;
        n_o_valid = r_o_valid && !i_rsp_ready;
        n_rsp     = r_rsp;
        mem_we    = 1'b0;
        mem_wbyte = r_wdata[8*r_idx[2:0] +: 8];
        rdata_upd = r_rdata;
        rdata_upd[8*r_rd_slot +: 8] = r_mem_q;
        case (r_state)
            B_IDLE: begin
                if (i_cfg_wr_en) begin
                    n_cap  = cfg_cap;
                    n_wpos = '0;
                    n_rpos = '0;
                    n_fill = '0;
                end else if (start) begin
                    n_xcnt  = d_count;
                    n_idx   = '0;
                    n_wdata = i_cmd.wdata;
                    n_rdata = '0;
                    if (d_send) begin
                        n_fill = r_fill + CW'(d_count);
                    end else if (d_recv) begin
                        n_fill = r_fill - CW'(d_count);
                    end else begin
                        if (d_empty) begin
                            n_wpos = '0;
                            n_rpos = '0;
                            n_fill = '0;
                        end
                        n_o_valid        = 1'b1;
                        n_rsp            = d_rsp;
                        n_rsp.free_bytes = CAP_W'(r_cap - n_fill);
                    end
                end
            end
            B_SEND: begin
                mem_we = 1'b1;
                n_wpos = bump(r_wpos, r_cap);
                n_idx  = r_idx + 1'b1;
                if (r_idx == r_xcnt - 1'b1) begin
                    n_o_valid        = 1'b1;
                    n_rsp            = '0;
                    n_rsp.status     = ST_OK;
                    n_rsp.byte_count = r_xcnt;
                    n_rsp.free_bytes = CAP_W'(r_cap - r_fill);
                end
            end
            B_RECV: begin
                if (r_idx < r_xcnt) begin
                    n_rpos    = bump(r_rpos, r_cap);
                    n_idx     = r_idx + 1'b1;
                    n_rd_pend = 1'b1;
                    n_rd_slot = r_idx[2:0];
                end
                if (r_rd_pend) begin
                    n_rdata = rdata_upd;
                    if (r_rd_slot == 3'(r_xcnt - 1'b1)) begin
                        n_o_valid        = 1'b1;
                        n_rsp            = '0;
                        n_rsp.status     = ST_OK;
                        n_rsp.byte_count = r_xcnt;
                        n_rsp.read_data  = rdata_upd;
                        n_rsp.free_bytes = CAP_W'(r_cap - r_fill);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_wpos] <= mem_wbyte;
        end
        r_mem_q <= mem[r_rpos];
    end

    always_ff @(posedge i_clk) begin
        r_xcnt    <= n_xcnt;
        r_idx     <= n_idx;
        r_wdata   <= n_wdata;
        r_rdata   <= n_rdata;
        r_rd_slot <= n_rd_slot;
        r_rsp     <= n_rsp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= B_IDLE;
            r_cap     <= CW'(STORE_DEPTH);
            r_wpos    <= '0;
            r_rpos    <= '0;
            r_fill    <= '0;
            r_rd_tot  <= '0;
            r_wr_tot  <= '0;
            r_rd_pend <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cap     <= n_cap;
            r_wpos    <= n_wpos;
            r_rpos    <= n_rpos;
            r_fill    <= n_fill;
            r_rd_pend <= n_rd_pend;
            r_o_valid <= n_o_valid;
            if (start) begin
                r_rd_tot <= n_rd_tot;
                r_wr_tot <= n_wr_tot;
            end
        end
    end

endmodule

### rtl/pipe_channel_byte_fifo.sv
// An input beat is queued in the front end and dispatched by the back end, which
// registers the result beat; a send or receive first moves its bytes one per cycle
// through the byte-wide store, so no new request starts until it is done. Control
// and poll requests are taken one per cycle while the result output is not stalled.
// Reset: synchronous active low; clears positions, fill, reader/writer counts
// and sets capacity to the store depth. Store contents are not cleared.
module pipe_channel_byte_fifo
    import pcbf_pkg::*;
#(
    parameter int unsigned STORE_DEPTH = STORE_DEPTH_DEF,
    parameter int unsigned MAX_XFER    = MAX_XFER_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [CAP_W-1:0]     i_cfg_wr_data,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // length[3:0], write_data[67:4], poll_reader[68], poll_writer[69], zero pad
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // req_type[2:0]
    input  logic [S_TUSER_W-1:0] s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // status[2:0], byte_count[6:3], read_data[70:7], poll_in[71], poll_out[72],
    // poll_hup[73], poll_err[74], free_bytes[87:75], channel_released[88], zero pad
    output logic [M_TDATA_W-1:0] m_axis_tdata
);

    t_cmd cmd;
    logic cmd_valid, cmd_pop;
    t_rsp rsp;

    pcbf_front #(
        .MAX_XFER (MAX_XFER)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .o_cmd         (cmd),
        .o_cmd_valid   (cmd_valid),
        .i_cmd_pop     (cmd_pop)
    );

    pcbf_back #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_cmd         (cmd),
        .i_cmd_valid   (cmd_valid),
        .o_cmd_pop     (cmd_pop),
        .o_rsp         (rsp),
        .o_rsp_valid   (m_axis_tvalid),
        .i_rsp_ready   (m_axis_tready)
    );

    always_comb begin
        m_axis_tdata          = '0;
        m_axis_tdata[2:0]     = rsp.status;
        m_axis_tdata[6:3]     = rsp.byte_count;
        m_axis_tdata[70:7]    = rsp.read_data;
        m_axis_tdata[71]      = rsp.poll_in;
        m_axis_tdata[72]      = rsp.poll_out;
        m_axis_tdata[73]      = rsp.poll_hup;
        m_axis_tdata[74]      = rsp.poll_err;
        m_axis_tdata[87:75]   = rsp.free_bytes;
        m_axis_tdata[88]      = rsp.released;
    end

endmodule

### rtl/pcbf_checker.sv
module pcbf_checker
    import pcbf_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_cfg_wr_en,
    input logic [CAP_W-1:0]     i_cfg_wr_data,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic [S_TDATA_W-1:0] s_axis_tdata,
    input logic [S_TUSER_W-1:0] s_axis_tuser,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata
);

    logic [2:0] st;
    logic [3:0] cnt;

    assign st  = m_axis_tdata[2:0];
    assign cnt = m_axis_tdata[6:3];

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> cnt <= 4'(BYTES))
        else $error("byte count above eight");

    a_cnt_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (cnt != 4'd0) |-> st == ST_OK)
        else $error("bytes moved with error status");

    a_hup_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[73] |-> m_axis_tdata[71])
        else $error("hangup without readable");

    a_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[88] |-> (st == ST_OK) && (cnt == 4'd0))
        else $error("release with bad status or count");

endmodule

bind pipe_channel_byte_fifo pcbf_checker u_pcbf_checker (.*);

### tb/pipe_channel_byte_fifo_tb.sv
module pipe_channel_byte_fifo_tb;
    import pcbf_pkg::*;

    localparam logic [2:0]  REQ_UNKNOWN = 3'd7;
    localparam int unsigned XFER_MAX    = MAX_XFER_DEF;
    localparam int unsigned RING_SLOTS  = STORE_DEPTH_DEF;
    localparam int          HOLD_CYCLES = 300;
    localparam int          QUIET_LIMIT = 4000;

    typedef struct packed {
        logic [2:0]        req;
        logic [LEN_W-1:0]  len;
        logic [DATA_W-1:0] wdata;
        logic              ask_r;
        logic              ask_w;
    } t_req_beat;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_wr_en = 1'b0;
    logic [CAP_W-1:0]     i_cfg_wr_data = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    // length[3:0], write_data[67:4], poll_reader[68], poll_writer[69], zero pad
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    // req_type[2:0]
    logic [S_TUSER_W-1:0] s_axis_tuser = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // status[2:0], byte_count[6:3], read_data[70:7], poll_in[71], poll_out[72],
    // poll_hup[73], poll_err[74], free_bytes[87:75], channel_released[88], zero pad
    logic [M_TDATA_W-1:0] m_axis_tdata;

    // channel shadow state
    logic [7:0] ring_mem [RING_SLOTS];
    int wr_ptr = 0;
    int rd_ptr = 0;
    int fill_cnt = 0;
    int rd_total = 0;
    int wr_total = 0;
    int cap_slots = RING_SLOTS;

    t_req_beat pending_q[$];
    t_rsp      expected_rsp_q[$];

    int gen_rd = 0;
    int gen_wr = 0;
    int queued_total = 0;
    int mismatches = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_arm = 1'b0;
    bit hold_taken = 1'b0;
    int hold_left = 0;
    int quiet_cycles = 0;

    pipe_channel_byte_fifo dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    function automatic void clear_ring();
        wr_ptr = 0;
        rd_ptr = 0;
        fill_cnt = 0;
    endfunction

    function automatic t_rsp channel_step(t_req_beat b);
        t_rsp r;
        int len;
        int n;
        int i;
        r = '0;
        n = 0;
        len = (b.len > XFER_MAX) ? XFER_MAX : b.len;
        case (b.req)
            REQ_SEND: begin
                if (len != 0 && rd_total == 0) begin
                    r.status = ST_PIPE;
                end else if (len != 0 && fill_cnt == cap_slots) begin
                    r.status = ST_BLOCK;
                end else if (len != 0) begin
                    n = (len < cap_slots - fill_cnt) ? len : cap_slots - fill_cnt;
                    for (i = 0; i < n; i++) begin
                        ring_mem[wr_ptr] = b.wdata[8*i +: 8];
                        wr_ptr = (wr_ptr + 1 >= cap_slots) ? 0 : wr_ptr + 1;
                    end
                    fill_cnt += n;
                end
            end
            REQ_RECV: begin
                if (len != 0 && fill_cnt == 0) begin
                    r.status = (wr_total == 0) ? ST_EOS : ST_BLOCK;
                end else if (len != 0) begin
                    n = (len < fill_cnt) ? len : fill_cnt;
                    for (i = 0; i < n; i++) begin
                        r.read_data[8*i +: 8] = ring_mem[rd_ptr];
                        rd_ptr = (rd_ptr + 1 >= cap_slots) ? 0 : rd_ptr + 1;
                    end
                    fill_cnt -= n;
                end
            end
            REQ_POLL: begin
                if (b.ask_r) begin
                    r.poll_in  = fill_cnt > 0 || wr_total == 0;
                    r.poll_hup = wr_total == 0;
                end
                if (b.ask_w) begin
                    r.poll_out = fill_cnt < cap_slots && rd_total > 0;
                    r.poll_err = rd_total == 0;
                end
            end
            REQ_ADD_RD: begin
                if (rd_total < 255) rd_total++;
            end
            REQ_ADD_WR: begin
                if (wr_total < 255) wr_total++;
            end
            REQ_DEL_RD: begin
                if (rd_total == 0) begin
                    r.status = ST_COUNT;
                end else begin
                    rd_total--;
                    if (rd_total == 0 && wr_total == 0) begin
                        clear_ring();
                        r.released = 1'b1;
                    end
                end
            end
            REQ_DEL_WR: begin
                if (wr_total == 0) begin
                    r.status = ST_COUNT;
                end else begin
                    wr_total--;
                    if (wr_total == 0 && rd_total == 0) begin
                        clear_ring();
                        r.released = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        r.byte_count = LEN_W'(n);
        r.free_bytes = CAP_W'(cap_slots - fill_cnt);
        return r;
    endfunction

    task automatic cmp(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    task automatic check_rsp(logic [M_TDATA_W-1:0] d);
        t_rsp e;
        if (expected_rsp_q.size() == 0) begin
            $error("result beat with nothing expected: %h", d);
            mismatches++;
        end else begin
            e = expected_rsp_q.pop_front();
            cmp("status", 64'(e.status), 64'(d[2:0]));
            cmp("byte_count", 64'(e.byte_count), 64'(d[6:3]));
            cmp("read_data", e.read_data, d[70:7]);
            cmp("poll_in", 64'(e.poll_in), 64'(d[71]));
            cmp("poll_out", 64'(e.poll_out), 64'(d[72]));
            cmp("poll_hup", 64'(e.poll_hup), 64'(d[73]));
            cmp("poll_err", 64'(e.poll_err), 64'(d[74]));
            cmp("free_bytes", 64'(e.free_bytes), 64'(d[87:75]));
            cmp("channel_released", 64'(e.released), 64'(d[88]));
        end
    endtask

    // input side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if ((s_axis_tvalid && s_axis_tready) || !s_axis_tvalid) begin
            if (s_axis_tvalid && s_axis_tready)
                expected_rsp_q.push_back(channel_step(pending_q.pop_front()));
            if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {2'b00, pending_q[0].ask_w, pending_q[0].ask_r,
                                  pending_q[0].wdata, pending_q[0].len};
                s_axis_tuser  <= pending_q[0].req;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // output side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready)
                check_rsp(m_axis_tdata);
            m_axis_tready <= hold_left == 0 && $urandom_range(99) >= recv_stall_pct;
        end
    end

    // long receiver hold-off, once
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left  <= 0;
            hold_taken <= 1'b0;
        end else if (hold_arm && !hold_taken) begin
            hold_left  <= HOLD_CYCLES;
            hold_taken <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_wr_en || (s_axis_tvalid && s_axis_tready)
                || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic int rand_len();
        if ($urandom_range(99) < 8) return 0;
        if ($urandom_range(99) < 10) return $urandom_range(15, 9);
        return $urandom_range(8, 1);
    endfunction

    task automatic push_req(logic [2:0] req, int len, logic [63:0] data, bit ar, bit aw);
        t_req_beat b;
        b.req   = req;
        b.len   = LEN_W'(len);
        b.wdata = data;
        b.ask_r = ar;
        b.ask_w = aw;
        pending_q.push_back(b);
        queued_total++;
        case (req)
            REQ_ADD_RD: if (gen_rd < 255) gen_rd++;
            REQ_ADD_WR: if (gen_wr < 255) gen_wr++;
            REQ_DEL_RD: if (gen_rd > 0) gen_rd--;
            REQ_DEL_WR: if (gen_wr > 0) gen_wr--;
            default: ;
        endcase
    endtask

    task automatic push_ctl(logic [2:0] req);
        push_req(req, $urandom_range(15), rand64(), 1'($urandom_range(1)),
                 1'($urandom_range(1)));
    endtask

    task automatic push_traffic(int send_bias);
        if ($urandom_range(99) < 12)
            push_req(REQ_POLL, rand_len(), rand64(), 1'($urandom_range(1)),
                     1'($urandom_range(1)));
        else if ($urandom_range(99) < send_bias)
            push_req(REQ_SEND, rand_len(), rand64(), 1'($urandom_range(1)),
                     1'($urandom_range(1)));
        else
            push_req(REQ_RECV, rand_len(), rand64(), 1'($urandom_range(1)),
                     1'($urandom_range(1)));
    endtask

    task automatic push_session(int send_bias);
        if (gen_rd == 0 || $urandom_range(99) < 25) push_ctl(REQ_ADD_RD);
        if (gen_wr == 0 || $urandom_range(99) < 25) push_ctl(REQ_ADD_WR);
        repeat ($urandom_range(24, 4)) push_traffic(send_bias);
        if ($urandom_range(99) < 70) push_ctl(REQ_DEL_WR);
        repeat ($urandom_range(3)) push_traffic(send_bias);
        if ($urandom_range(99) < 70) push_ctl(REQ_DEL_RD);
        if ($urandom_range(99) < 8) repeat (gen_rd + 1) push_ctl(REQ_DEL_RD);
        if ($urandom_range(99) < 8) repeat (gen_wr + 1) push_ctl(REQ_DEL_WR);
    endtask

    task automatic fill_random(int n);
        int stop;
        stop = queued_total + n;
        while (queued_total < stop) begin
            if ($urandom_range(99) < 15)
                push_req(3'($urandom_range(7)), $urandom_range(15), rand64(),
                         1'($urandom_range(1)), 1'($urandom_range(1)));
            else
                push_session(20 + 30 * $urandom_range(2));
        end
    endtask

    task automatic drain();
        while (pending_q.size() != 0 || expected_rsp_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_capacity(int v);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= CAP_W'(v);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        cap_slots = (v == 0) ? 1 : (v > RING_SLOTS) ? RING_SLOTS : v;
        clear_ring();
    endtask

    task automatic run_phase(int cap, int sidle, int rstall, int n);
        set_capacity(cap);
        send_idle_pct  = sidle;
        recv_stall_pct = rstall;
        fill_random(n);
        drain();
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty channel, no endpoints, full reset capacity
        push_req(REQ_RECV, 4, 64'h0, 0, 0);
        push_req(REQ_SEND, 3, 64'h0123_4567_89AB_CDEF, 0, 0);
        push_req(REQ_POLL, 0, 64'h0, 1, 1);
        push_req(REQ_DEL_RD, 0, 64'h0, 0, 0);
        push_req(REQ_DEL_WR, 0, 64'h0, 0, 0);
        push_req(REQ_UNKNOWN, 15, 64'hFFFF_FFFF_FFFF_FFFF, 1, 1);
        push_req(REQ_ADD_RD, 0, 64'h0, 0, 0);
        push_req(REQ_ADD_WR, 0, 64'h0, 0, 0);
        push_req(REQ_SEND, 0, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0);
        push_req(REQ_RECV, 0, 64'h0, 0, 0);
        push_req(REQ_RECV, 8, 64'h0, 0, 0);
        push_req(REQ_SEND, 15, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0);
        push_req(REQ_SEND, 8, 64'hFEDC_BA98_7654_3210, 0, 0);
        push_req(REQ_POLL, 0, 64'h0, 1, 1);
        push_req(REQ_RECV, 12, 64'h0, 0, 0);
        push_req(REQ_RECV, 8, 64'h0, 0, 0);
        push_req(REQ_RECV, 1, 64'h0, 0, 0);
        push_req(REQ_DEL_WR, 0, 64'h0, 0, 0);
        push_req(REQ_RECV, 1, 64'h0, 1, 1);
        push_req(REQ_POLL, 0, 64'h0, 1, 1);
        push_req(REQ_DEL_RD, 0, 64'h0, 0, 0);
        drain();

        // zero capacity taken as one slot; release with data still stored
        set_capacity(0);
        push_req(REQ_ADD_RD, 0, 64'h0, 0, 0);
        push_req(REQ_ADD_WR, 0, 64'h0, 0, 0);
        push_req(REQ_SEND, 8, 64'h1122_3344_5566_77A5, 0, 0);
        push_req(REQ_SEND, 1, 64'h5A, 0, 0);
        push_req(REQ_POLL, 0, 64'h0, 0, 1);
        push_req(REQ_RECV, 8, 64'h0, 0, 0);
        push_req(REQ_SEND, 2, 64'h3C, 0, 0);
        push_req(REQ_DEL_RD, 0, 64'h0, 0, 0);
        push_req(REQ_DEL_WR, 0, 64'h0, 0, 0);
        fill_random(30);
        drain();

        run_phase(5, 81, 0, 35);
        run_phase(17, 0, 81, 35);
        run_phase(8191, 29, 29, 35);

        // receiver stops for a long stretch while the sender keeps offering
        set_capacity(3);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        fill_random(60);
        hold_arm <= 1'b1;
        drain();

        run_phase(64, 29, 29, 35);
        run_phase(4097, 0, 0, 30);
        run_phase(2, 0, 81, 35);
        run_phase(9, 81, 0, 35);

        // drive both endpoint counts into saturation
        set_capacity(12);
        send_idle_pct  = 29;
        recv_stall_pct = 29;
        repeat (270) begin
            push_ctl(REQ_ADD_RD);
            push_ctl(REQ_ADD_WR);
            if ($urandom_range(9) == 0) push_traffic(50);
        end
        repeat (4) begin
            push_ctl(REQ_DEL_RD);
            push_ctl(REQ_ADD_WR);
            push_ctl(REQ_ADD_RD);
            push_traffic(50);
            push_ctl(REQ_ADD_RD);
            push_ctl(REQ_POLL);
        end
        drain();

        repeat (20) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
